// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Concurrent check that also holds while reset is low.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: rtl/dcg_pkg.sv
// ----------------------------------------------------------------------------
// dcg_pkg
// Shared types and constants of the drive command generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dcg_pkg;

  localparam int SPEED_W    = 16;
  localparam int TURN_W     = 18;
  localparam int CFG_W      = 15;
  localparam int BYTE_W     = 8;
  localparam int DIVIDEND_W = 25;   // |speed| * 1000 fits in 25 bits
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [SPEED_W-1:0] SPEED_MAX        = 16'sd500;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN        = -16'sd500;
  localparam logic signed [SPEED_W-1:0] POINT_TURN_SPEED = 16'sd200;
  localparam logic signed [TURN_W-1:0]  TURN_SAT_MAX     = 18'sd131071;
  localparam logic signed [TURN_W-1:0]  TURN_SAT_MIN     = -18'sd131072;
  localparam logic [DIVIDEND_W-1:0]     RADIUS_LIMIT     = 25'd2000;
  localparam logic [9:0]                RADIUS_SCALE     = 10'd1000;
  localparam logic [15:0]               STRAIGHT_CODE    = 16'h8000;
  localparam logic [15:0]               RADIUS_PLUS_ONE  = 16'h0001;
  localparam logic [15:0]               RADIUS_MINUS_ONE = 16'hFFFF;
  localparam logic [BYTE_W-1:0]         DRIVE_OPCODE     = 8'd137;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 15'd100;
  localparam logic [CFG_W-1:0] INCREMENT_RESET = 15'd50;

  // Register indexes on the configuration port
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_INCREMENT = 1'b1;

  typedef enum logic [1:0] {
    RAD_DIVIDE,
    RAD_STRAIGHT,
    RAD_POINT_POS,
    RAD_POINT_NEG
  } rad_mode_e;

  typedef struct packed {
    logic [CFG_W-1:0] threshold;
    logic [CFG_W-1:0] increment;
  } cfg_t;

  // One classified command waiting for the radius divide and byte output
  typedef struct packed {
    logic [SPEED_W-1:0] speed;      // clamped speed, or the point-turn speed; two's complement
    logic [SPEED_W-1:0] speed_mag;  // |raw speed|
    logic [TURN_W-1:0]  turn_mag;   // |limited turn|
    logic               rad_neg;
    rad_mode_e          mode;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/dcg_front.sv
// ----------------------------------------------------------------------------
// dcg_front
// Slew-limits the turn rate, clamps the speed and decides whether a command
// goes out; classified commands are pushed into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dcg_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dcg_pkg::cfg_t                 cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [15:0]            drive_speed_i,
  input  wire logic signed [15:0]            turn_rate_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output dcg_pkg::cmd_t                      q_data_o
);
  import dcg_pkg::*;

  logic signed [TURN_W-1:0]  prev_turn_q, prev_turn_d;
  logic signed [SPEED_W-1:0] prev_speed_q, prev_speed_d;
  logic signed [SPEED_W-1:0] prev_turn_in_q, prev_turn_in_d;
  logic                      sent_once_q, sent_once_d;

  logic                      accept;
  logic [TURN_W-1:0]         prev_mag;
  logic [TURN_W-1:0]         in_mag;
  logic signed [TURN_W:0]    diff;
  logic [TURN_W:0]           diff_mag;
  logic                      limit;
  logic signed [TURN_W:0]    stepped;
  logic signed [TURN_W-1:0]  turn_new;
  logic signed [SPEED_W-1:0] speed_c;
  logic                      emit;

  always_comb begin
    prev_mag = prev_turn_q[TURN_W-1] ? TURN_W'(-prev_turn_q) : TURN_W'(prev_turn_q);
    in_mag   = turn_rate_i[15] ? TURN_W'(-{{(TURN_W-16){1'b1}}, turn_rate_i})
                               : TURN_W'(turn_rate_i);
    diff     = $signed({1'b0, prev_mag}) - $signed({1'b0, in_mag});
    diff_mag = diff[TURN_W] ? (TURN_W+1)'(-diff) : (TURN_W+1)'(diff);
    limit    = (diff_mag > (TURN_W+1)'(cfg_i.threshold)) && (turn_rate_i != '0);

    if (diff > 0) begin
      stepped = $signed({prev_turn_q[TURN_W-1], prev_turn_q}) +
                $signed({{(TURN_W+1-CFG_W){1'b0}}, cfg_i.increment});
    end else begin
      stepped = $signed({prev_turn_q[TURN_W-1], prev_turn_q}) -
                $signed({{(TURN_W+1-CFG_W){1'b0}}, cfg_i.increment});
    end

    if (!limit) begin
      turn_new = TURN_W'(turn_rate_i);
    end else if (stepped > $signed({TURN_SAT_MAX[TURN_W-1], TURN_SAT_MAX})) begin
      turn_new = TURN_SAT_MAX;
    end else if (stepped < $signed({TURN_SAT_MIN[TURN_W-1], TURN_SAT_MIN})) begin
      turn_new = TURN_SAT_MIN;
    end else begin
      turn_new = stepped[TURN_W-1:0];
    end

    if (drive_speed_i > SPEED_MAX) begin
      speed_c = SPEED_MAX;
    end else if (drive_speed_i < SPEED_MIN) begin
      speed_c = SPEED_MIN;
    end else begin
      speed_c = drive_speed_i;
    end

    q_data_o.speed_mag = drive_speed_i[15] ? SPEED_W'(-drive_speed_i)
                                           : SPEED_W'(drive_speed_i);
    q_data_o.turn_mag  = turn_new[TURN_W-1] ? TURN_W'(-turn_new) : TURN_W'(turn_new);
    q_data_o.rad_neg   = drive_speed_i[15] ^ turn_new[TURN_W-1];

    // Zero turn drives straight; zero speed with a turn spins in place
    if (turn_new == '0) begin
      q_data_o.mode  = RAD_STRAIGHT;
      q_data_o.speed = speed_c;
    end else if (drive_speed_i == '0) begin
      q_data_o.mode  = turn_new[TURN_W-1] ? RAD_POINT_NEG : RAD_POINT_POS;
      q_data_o.speed = POINT_TURN_SPEED;
    end else begin
      q_data_o.mode  = RAD_DIVIDE;
      q_data_o.speed = speed_c;
    end

    emit = !sent_once_q || (q_data_o.speed != prev_speed_q) ||
           (turn_rate_i != prev_turn_in_q);
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && emit;

  always_comb begin
    prev_turn_d    = prev_turn_q;
    prev_speed_d   = prev_speed_q;
    prev_turn_in_d = prev_turn_in_q;
    sent_once_d    = sent_once_q;
    if (accept) begin
      prev_turn_d = turn_new;
    end
    if (q_push_o) begin
      prev_speed_d   = q_data_o.speed;
      prev_turn_in_d = turn_rate_i;
      sent_once_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_turn_q    <= '0;
      prev_speed_q   <= '0;
      prev_turn_in_q <= '0;
      sent_once_q    <= 1'b0;
    end else begin
      prev_turn_q    <= prev_turn_d;
      prev_speed_q   <= prev_speed_d;
      prev_turn_in_q <= prev_turn_in_d;
      sent_once_q    <= sent_once_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dcg_queue.sv
// ----------------------------------------------------------------------------
// dcg_queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dcg_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire dcg_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output dcg_pkg::cmd_t      pop_data_o,
  output logic               empty_o
);
  import dcg_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dcg_back.sv
// ----------------------------------------------------------------------------
// dcg_back
// Computes the turning radius, with a bit-serial divider for divided commands,
// and sends the five command bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module dcg_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire dcg_pkg::cmd_t q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         command_byte_o,
  output logic               last_byte_o
);
  import dcg_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_SEND = 3'd4;

  localparam int STEP_W = $clog2(DIVIDEND_W);

  localparam logic [2:0] BYTE_OP       = 3'd0;
  localparam logic [2:0] BYTE_SPEED_HI = 3'd1;
  localparam logic [2:0] BYTE_SPEED_LO = 3'd2;
  localparam logic [2:0] BYTE_RAD_HI   = 3'd3;
  localparam logic [2:0] BYTE_RAD_LO   = 3'd4;

  logic [2:0]            state_q, state_d;
  cmd_t                  cmd_q, cmd_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;      // dividend shifts out, quotient in
  logic [TURN_W-1:0]     rem_q, rem_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [15:0]           radius_q, radius_d;
  logic [2:0]            byte_q, byte_d;

  logic [TURN_W:0]       rem_shift;
  logic [TURN_W:0]       divisor;
  logic                  fits;
  logic                  out_fire;

  assign rem_shift = {rem_q, quo_q[DIVIDEND_W-1]};
  assign divisor   = {1'b0, cmd_q.turn_mag};
  assign fits      = (rem_shift >= divisor);
  assign q_pop_o   = (state_q == ST_IDLE) && !q_empty_i;
  assign out_valid_o = (state_q == ST_SEND);
  assign out_fire  = out_valid_o && out_ready_i;
  assign last_byte_o = (byte_q == BYTE_RAD_LO);

  always_comb begin
    case (byte_q)
      BYTE_OP:       command_byte_o = DRIVE_OPCODE;
      BYTE_SPEED_HI: command_byte_o = cmd_q.speed[15:8];
      BYTE_SPEED_LO: command_byte_o = cmd_q.speed[7:0];
      BYTE_RAD_HI:   command_byte_o = radius_q[15:8];
      BYTE_RAD_LO:   command_byte_o = radius_q[7:0];
      default:       command_byte_o = DRIVE_OPCODE;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    step_d   = step_q;
    radius_d = radius_q;
    byte_d   = byte_q;
    case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          cmd_d   = q_data_i;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        quo_d   = DIVIDEND_W'(cmd_q.speed_mag) * DIVIDEND_W'(RADIUS_SCALE);
        rem_d   = '0;
        step_d  = '0;
        state_d = (cmd_q.mode == RAD_DIVIDE) ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        // One restoring step per cycle, MSB first
        if (fits) begin
          rem_d = TURN_W'(rem_shift - divisor);
        end else begin
          rem_d = rem_shift[TURN_W-1:0];
        end
        quo_d  = {quo_q[DIVIDEND_W-2:0], fits};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIVIDEND_W - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        case (cmd_q.mode)
          RAD_STRAIGHT:  radius_d = STRAIGHT_CODE;
          RAD_POINT_POS: radius_d = RADIUS_PLUS_ONE;
          RAD_POINT_NEG: radius_d = RADIUS_MINUS_ONE;
          RAD_DIVIDE: begin
            if (quo_q > RADIUS_LIMIT) begin
              radius_d = STRAIGHT_CODE;
            end else if (cmd_q.rad_neg) begin
              radius_d = 16'(-quo_q[15:0]);
            end else begin
              radius_d = quo_q[15:0];
            end
          end
          default: radius_d = STRAIGHT_CODE;
        endcase
        byte_d  = BYTE_OP;
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (out_fire) begin
          byte_d = byte_q + 1'b1;
          if (last_byte_o) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    radius_q <= radius_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      byte_q  <= BYTE_OP;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      byte_q  <= byte_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/drive_command_generator.sv
// ----------------------------------------------------------------------------
// drive_command_generator
// Turns speed and turn-rate requests into five-byte wheel drive commands.
// ----------------------------------------------------------------------------
//  channel   signals                                    direction
//  input     in_valid_i/in_ready_o, drive_speed_i,       in
//            turn_rate_i
//  output    out_valid_o/out_ready_i, command_byte_o,    out
//            last_byte_o
//  config    psel, penable, pwrite, paddr, pwdata,       in/out
//            prdata, pready
//
//  A divided command holds the back through queue pop, product, 25 divider
//  steps, radius select and 5 bytes; straight and point turns skip the divider
//  steps. The serial divider sets the pace. A silent item is taken with no queue
//  push; the front takes an item each cycle while the two-entry queue has room.
//  Reset is asynchronous, active low; it restores both registers and clears
//  the turn and last-sent history. Output stalls hold the current byte.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_command_generator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] drive_speed_i,
  input  wire logic signed [15:0] turn_rate_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              command_byte_o,
  output logic                    last_byte_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import dcg_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic cfg_write;
  logic reg_sel;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wr_data, q_rd_data;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (reg_sel)
        REG_THRESHOLD: cfg_d.threshold = pwdata[CFG_W-1:0];
        REG_INCREMENT: cfg_d.increment = pwdata[CFG_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_THRESHOLD: prdata = 32'(cfg_q.threshold);
      REG_INCREMENT: prdata = 32'(cfg_q.increment);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESHOLD_RESET;
      cfg_q.increment <= INCREMENT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dcg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .drive_speed_i (drive_speed_i),
    .turn_rate_i   (turn_rate_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wr_data)
  );

  dcg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wr_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rd_data),
    .empty_o     (q_empty)
  );

  dcg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (q_rd_data),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_byte_o (command_byte_o),
    .last_byte_o    (last_byte_o)
  );

endmodule

`default_nettype wire

// File: rtl/dcg_checker.sv
// ----------------------------------------------------------------------------
// dcg_checker
// Port-level checks on the drive command generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dcg_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic signed [15:0] drive_speed_i,
  input wire logic signed [15:0] turn_rate_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [7:0]         command_byte_o,
  input wire logic               last_byte_o,
  input wire logic               psel,
  input wire logic               penable,
  input wire logic               pwrite,
  input wire logic [2:0]         paddr,
  input wire logic [31:0]        pwdata,
  input wire logic [31:0]        prdata,
  input wire logic               pready
);

  logic        in_stall;
  logic [31:0] in_word;
  logic        out_stall;
  logic        out_step;
  logic [8:0]  out_word;
  logic        thr_write;
  logic        thr_sel;
  logic [14:0] wr_val;

  assign in_stall  = in_valid_i && !in_ready_o;
  assign in_word   = {drive_speed_i, turn_rate_i};
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_step  = out_valid_o && out_ready_i && !last_byte_o;
  assign out_word  = {command_byte_o, last_byte_o};
  assign thr_write = psel && penable && pwrite && pready && !paddr[2];
  assign thr_sel   = !paddr[2];
  assign wr_val    = pwdata[14:0];

  // A waiting input item holds
  `ASSERT_CLK(a_in_hold, clk_i, rst_ni, in_stall |=> in_valid_i && $stable(in_word))

  // A stalled byte holds
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(out_word))

  // The bytes of one command follow without a gap
  `ASSERT_CLK(a_cmd_unbroken, clk_i, rst_ni, out_step |=> out_valid_o)

  // A threshold write reads back on the next cycle
  `ASSERT_CLK(a_thr_readback, clk_i, rst_ni, thr_write ##1 thr_sel |-> prdata[14:0] == $past(wr_val))

  // Registers are 15 bits; upper read data stays zero
  `ASSERT_ALWAYS(a_prdata_upper, clk_i, prdata[31:15] == '0)

endmodule

bind drive_command_generator dcg_checker u_dcg_checker (.*);

`default_nettype wire
